// ----- design/rfft_pkg.sv -----
package rfft_pkg;

  // configuration register indexes
  localparam int unsigned RegLog2Points = 0;
  localparam int unsigned RegScaleShift = 1;

  localparam int unsigned SampleW = 16;
  localparam int unsigned BinW    = 6;
  localparam int unsigned CfgW    = 5;
  localparam int unsigned IdxW    = 1;

  // sequencer states
  typedef enum logic [6:0] {
    StLoad  = 7'b0000001,
    StSwapA = 7'b0000010,
    StSwapB = 7'b0000100,
    StBfRd  = 7'b0001000,
    StBfMul = 7'b0010000,
    StBfWr  = 7'b0100000,
    StEmit  = 7'b1000000
  } state_e;

endpackage

// ----- design/real_fft_ccs_scaled_core.sv -----
// Real-input radix-2 decimation-in-time FFT. Collect 2^log2_points signed
// samples, one per cycle; the last sample starts the transform: a bit-reverse
// pass that leaves each index in place or swaps it with its reverse, then
// log2(N)*N/2 butterflies (read, multiply while the second operand is read,
// capture, then two writes since the working memory takes one write per
// cycle), then N/2+1 bins leave at one per cycle when the consumer is ready.
// Outputs are rounded, shifted right by scale_shift and saturated to 16
// bits; DC and Nyquist imaginary parts are zero and last_bin marks the
// Nyquist bin.
module real_fft_ccs_scaled_core #(
  parameter int unsigned MAX_POINTS   = 64,
  parameter int unsigned TWIDDLE_BITS = 16,
  parameter int unsigned WORK_BITS    = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rfft_pkg::IdxW-1:0]         cfg_idx_i,
  input  logic [rfft_pkg::CfgW-1:0]         cfg_data_i,
  input  logic                              sample_valid_i,
  output logic                              sample_ready_o,
  input  logic signed [rfft_pkg::SampleW-1:0] sample_i,
  output logic                              bin_valid_o,
  input  logic                              bin_ready_i,
  output logic [rfft_pkg::BinW-1:0]         bin_index_o,
  output logic signed [rfft_pkg::SampleW-1:0] bin_real_o,
  output logic signed [rfft_pkg::SampleW-1:0] bin_imag_o,
  output logic                              last_bin_o
);
  import rfft_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_POINTS);
  localparam int unsigned CW   = AW + 1;
  localparam int unsigned F    = TWIDDLE_BITS - 1;
  localparam int unsigned PW   = WORK_BITS + TWIDDLE_BITS;
  localparam int unsigned HALF = MAX_POINTS / 2;
  localparam int unsigned HW   = (AW > 1) ? AW - 1 : 1;
  localparam int unsigned SW   = $clog2(AW + 1);
  localparam real TW_STEP = 3.14159265358979323846 * 2.0 / real'(MAX_POINTS);

  typedef logic signed [WORK_BITS-1:0]    work_t;
  typedef logic signed [TWIDDLE_BITS-1:0] tw_t;

  // twiddle value: round(2^F * trig), capped at 2^F-1; the sine value is negated
  function automatic tw_t tw_val(input int unsigned i, input bit want_sin);
    real ang, v;
    longint r;
    begin
      ang = TW_STEP * real'(i);
      v   = want_sin ? $sin(ang) : $cos(ang);
      if (want_sin && v < 0.0) v = 0.0;
      r = longint'($floor(v * real'(64'd1 << F) + 0.5));
      if (r > longint'((64'd1 << F) - 1)) r = longint'((64'd1 << F) - 1);
      if (want_sin) r = -r;
      tw_val = tw_t'(r);
    end
  endfunction

  // ---------------- configuration ----------------
  logic [2:0] log2_q;
  logic [4:0] shift_q;
  logic [SW-1:0] order;
  always_comb begin
    if (log2_q < 3'd2) order = SW'(2);
    else if (32'(log2_q) > AW) order = SW'(AW);
    else order = SW'(log2_q);
  end

  // ---------------- working memory ----------------
  logic [2*WORK_BITS-1:0] mem [MAX_POINTS];
  logic                   mem_we;
  logic [AW-1:0]          mem_wa, mem_ra;
  logic [2*WORK_BITS-1:0] mem_wd, mem_rd_q;
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_q <= mem[mem_ra];
  end

  // ---------------- sequencer ----------------
  state_e        st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;            // load count / index / emit bin
  logic [SW-1:0] stage_q, stage_d;        // butterfly stage, span = 2^stage
  logic [AW-1:0] bf_q, bf_d;              // butterfly number in stage
  logic          rd2_q, rd2_d;            // second read of a pair
  logic [2*WORK_BITS-1:0] hold_q, hold_d; // first operand
  logic signed [WORK_BITS+1:0] pr_q, pi_q, pr_d, pi_d;
  logic          out_v_q;
  logic [BinW-1:0] out_idx_q;
  logic signed [SampleW-1:0] out_re_q, out_im_q;
  logic          out_last_q;

  logic [CW-1:0] n_pts;
  assign n_pts = CW'(1) << order;

  // bit reverse over 'order' bits
  logic [AW-1:0] rev;
  always_comb begin
    rev = '0;
    for (int b = 0; b < AW; b++)
      if (b < int'(order)) rev[b] = cnt_q[int'(order) - 1 - b];
  end

  // butterfly addresses
  logic [AW-1:0] span, x1, x2, lowm, tw_idx;
  always_comb begin
    span = AW'(1) << stage_q;
    lowm = bf_q & (span - AW'(1));
    x1   = ((bf_q & ~(span - AW'(1))) << 1) | lowm;
    x2   = x1 | span;
    tw_idx = AW'(lowm << (AW - 1 - int'(stage_q)));
  end

  tw_t tc, ts;
  always_comb begin
    tc = '0; ts = '0;
    for (int i = 0; i < HALF; i++)
      if (tw_idx[HW-1:0] == HW'(i)) begin
        tc = tw_val(i, 1'b0);
        ts = tw_val(i, 1'b1);
      end
  end

  // twiddle products, rounded half up
  work_t a_r, a_i;
  logic signed [PW:0] mr, mi;
  assign a_r = mem_rd_q[2*WORK_BITS-1:WORK_BITS];
  assign a_i = mem_rd_q[WORK_BITS-1:0];
  assign mr = (PW+1)'(a_r) * (PW+1)'(tc) - (PW+1)'(a_i) * (PW+1)'(ts)
            + (PW+1)'(1 << (F-1));
  assign mi = (PW+1)'(a_r) * (PW+1)'(ts) + (PW+1)'(a_i) * (PW+1)'(tc)
            + (PW+1)'(1 << (F-1));

  function automatic work_t sat_w(input logic signed [WORK_BITS+1:0] v);
    logic signed [WORK_BITS+1:0] hi, lo;
    begin
      hi = (WORK_BITS+2)'({1'b0, {(WORK_BITS-1){1'b1}}});
      lo = -hi - 1;
      sat_w = (v > hi) ? work_t'(hi) : (v < lo) ? work_t'(lo) : work_t'(v);
    end
  endfunction

  work_t h_r, h_i;
  logic signed [WORK_BITS+1:0] sr, si, dr, di, vr, vi;
  assign h_r = hold_q[2*WORK_BITS-1:WORK_BITS];
  assign h_i = hold_q[WORK_BITS-1:0];
  assign vr = pr_q;
  assign vi = pi_q;
  assign sr = (WORK_BITS+2)'(h_r) + vr;
  assign si = (WORK_BITS+2)'(h_i) + vi;
  assign dr = (WORK_BITS+2)'(h_r) - vr;
  assign di = (WORK_BITS+2)'(h_i) - vi;

  // output scaling
  function automatic logic signed [SampleW-1:0] scale(input work_t w,
                                                      input logic [4:0] sh);
    logic [WORK_BITS:0] mag;
    logic signed [WORK_BITS+2:0] r, k;
    begin
      mag = w[WORK_BITS-1] ? (WORK_BITS+1)'(-(WORK_BITS+1)'(w))
                           : (WORK_BITS+1)'(w);
      mag = (mag + (WORK_BITS+1)'(128)) >> 8;
      r = w[WORK_BITS-1] ? -(WORK_BITS+3)'(mag) : (WORK_BITS+3)'(mag);
      k = (sh == 5'd0) ? '0 : (WORK_BITS+3)'(1) <<< (sh - 5'd1);
      r = w[WORK_BITS-1] ? r - k : r + k;
      r = r >>> sh;
      if (r > 32767) scale = 16'sd32767;
      else if (r < -32768) scale = -16'sd32768;
      else scale = SampleW'(r);
    end
  endfunction

  logic out_free;
  assign out_free = !out_v_q || bin_ready_i;
  assign sample_ready_o = (st_q == StLoad);
  logic last_stage;
  assign last_stage = (stage_q == order - SW'(1));

  // next state
  always_comb begin
    st_d = st_q; cnt_d = cnt_q; stage_d = stage_q; bf_d = bf_q; rd2_d = rd2_q;
    hold_d = hold_q; pr_d = pr_q; pi_d = pi_q;
    mem_we = 1'b0; mem_wa = cnt_q[AW-1:0]; mem_wd = '0; mem_ra = cnt_q[AW-1:0];
    case (st_q)
      StLoad: begin
        mem_wd = {WORK_BITS'(sample_i) <<< 8, {WORK_BITS{1'b0}}};
        if (sample_valid_i) begin
          mem_we = 1'b1;
          if (cnt_q == n_pts - CW'(1)) begin
            cnt_d = '0; st_d = StSwapA;
          end else cnt_d = cnt_q + CW'(1);
        end
      end
      StSwapA: begin
        // read a[i]; then a[j]
        mem_ra = rd2_q ? rev : cnt_q[AW-1:0];
        if (CW'(rev) <= cnt_q) begin
          rd2_d = 1'b0;
          if (cnt_q == n_pts - CW'(1)) begin
            cnt_d = '0; stage_d = '0; bf_d = '0; st_d = StBfRd;
          end else cnt_d = cnt_q + CW'(1);
        end else if (!rd2_q) rd2_d = 1'b1;
        else begin
          hold_d = mem_rd_q;               // a[i] captured
          st_d = StSwapB;
        end
      end
      StSwapB: begin
        // a[j] is read again so it is present in the next cycle
        mem_ra = rev;
        rd2_d = 1'b0;
        st_d = StBfMul;                    // reuse as swap write stage
        cnt_d = cnt_q;
        stage_d = SW'(AW);                 // marks swap mode
      end
      StBfRd: begin
        mem_ra = x2;
        st_d = StBfMul;
      end
      StBfMul: begin
        if (stage_q == SW'(AW)) begin
          // swap: hold=a[i], rd=a[j]
          mem_we = 1'b1; mem_wa = cnt_q[AW-1:0]; mem_wd = mem_rd_q;
          st_d = StBfWr;
        end else begin
          // rd = a[x2]; capture products, read x1
          mem_ra = x1;
          pr_d = (WORK_BITS+2)'(mr >>> F); pi_d = (WORK_BITS+2)'(mi >>> F);
          hold_d = '0;
          st_d = StBfWr; rd2_d = 1'b1;
        end
      end
      StBfWr: begin
        if (stage_q == SW'(AW)) begin
          mem_we = 1'b1; mem_wa = rev; mem_wd = hold_q;
          st_d = StSwapA;
          if (cnt_q == n_pts - CW'(1)) begin
            cnt_d = '0; stage_d = '0; bf_d = '0; st_d = StBfRd;
          end else begin
            cnt_d = cnt_q + CW'(1); stage_d = '0;
          end
        end else if (rd2_q) begin
          // x1 arrives now
          hold_d = mem_rd_q; rd2_d = 1'b0;
        end else begin
          mem_we = 1'b1;
          mem_wa = x1; mem_wd = {sat_w(sr), sat_w(si)};
          st_d = StEmit; cnt_d = '1;
        end
      end
      StEmit: begin
        if (cnt_q == '1) begin
          // second butterfly write
          mem_we = 1'b1; mem_wa = x2; mem_wd = {sat_w(dr), sat_w(di)};
          cnt_d = '0; st_d = StBfRd;
          if (CW'(bf_q) == (n_pts >> 1) - CW'(1)) begin
            bf_d = '0;
            if (last_stage) st_d = StEmit;
            else stage_d = stage_q + SW'(1);
          end else bf_d = bf_q + AW'(1);
          mem_ra = '0;
        end else begin
          mem_ra = cnt_q[AW-1:0] + AW'(1);
          if (out_free) begin
            if (cnt_q == (n_pts >> 1)) begin
              cnt_d = '0; stage_d = '0; st_d = StLoad;
            end else cnt_d = cnt_q + CW'(1);
          end else mem_ra = cnt_q[AW-1:0];
        end
      end
      default: st_d = StLoad;
    endcase
    // a length write clears the count, which restarts collection while loading
    if (cfg_we_i && cfg_idx_i == IdxW'(RegLog2Points)) cnt_d = '0;
  end

  // the pending-read address in StBfWr with rd2 set must be x1
  // (StBfMul read issues x1 for the following cycle)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad; cnt_q <= '0; stage_q <= '0; bf_q <= '0; rd2_q <= 1'b0;
      log2_q <= 3'd6; shift_q <= '0; out_v_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; stage_q <= stage_d; bf_q <= bf_d;
      rd2_q <= rd2_d;
      if (cfg_we_i && cfg_idx_i == IdxW'(RegLog2Points)) log2_q <= cfg_data_i[2:0];
      if (cfg_we_i && cfg_idx_i == IdxW'(RegScaleShift)) shift_q <= cfg_data_i;
      if (st_q == StEmit && cnt_q != '1 && out_free) out_v_q <= 1'b1;
      else if (bin_ready_i) out_v_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d; pr_q <= pr_d; pi_q <= pi_d;
    if (st_q == StEmit && cnt_q != '1 && out_free) begin
      out_idx_q  <= BinW'(cnt_q);
      out_re_q   <= scale(mem_rd_q[2*WORK_BITS-1:WORK_BITS], shift_q);
      out_im_q   <= (cnt_q == '0 || cnt_q == (n_pts >> 1)) ? '0
                    : scale(mem_rd_q[WORK_BITS-1:0], shift_q);
      out_last_q <= (cnt_q == (n_pts >> 1));
    end
  end

  assign bin_valid_o = out_v_q;
  assign bin_index_o = out_idx_q;
  assign bin_real_o  = out_re_q;
  assign bin_imag_o  = out_im_q;
  assign last_bin_o  = out_last_q;

endmodule
